// ===== sv/priority_task_scheduler_with_events_assert.svh =====
// assertion macros used by the checker file
`ifndef PRIORITY_TASK_SCHEDULER_WITH_EVENTS_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_WITH_EVENTS_ASSERT_SVH

// same-cycle implication, held off during reset
`define PTS_CHK_NOW(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define PTS_CHK_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/pts_pkg.sv =====
package pts_pkg;

    // command codes
    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_DEL   = 3'd1;
    localparam logic [2:0] CMD_SCHED = 3'd2;
    localparam logic [2:0] CMD_SET   = 3'd3;
    localparam logic [2:0] CMD_CLR   = 3'd4;
    localparam logic [2:0] CMD_GET   = 3'd5;
    localparam logic [2:0] CMD_GCLR  = 3'd6;
    localparam logic [2:0] CMD_WAIT  = 3'd7;

    // slot states
    localparam logic [1:0] ST_EXITED  = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_IDLE = 2'd2;

    localparam int PRIO_W = 8;

    // sequencer to datapath
    typedef struct packed {
        logic load;
        logic add_step;
        logic sched_step;
        logic sched_end;
        logic ev_read;
        logic ev_update;
        logic out_load;
    } pts_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic [2:0] cmd;
        logic       add_hit;
        logic       add_last;
        logic       sched_last;
        logic       out_free;
    } pts_stat_t;

endpackage

// ===== sv/pts_ram.sv =====
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/pts_ctrl.sv =====
module pts_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pts_pkg::pts_stat_t stat,
    output pts_pkg::pts_ctrl_t ctrl
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DISP      = 3'd1;
    localparam logic [2:0] S_ADD       = 3'd2;
    localparam logic [2:0] S_SCHED     = 3'd3;
    localparam logic [2:0] S_SCHED_END = 3'd4;
    localparam logic [2:0] S_EV_RD     = 3'd5;
    localparam logic [2:0] S_EV_UPD    = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctrl.load  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (stat.cmd)
                    pts_pkg::CMD_ADD:   state_next = S_ADD;
                    pts_pkg::CMD_SCHED: state_next = S_SCHED;
                    default:            state_next = S_EV_RD;
                endcase
            end
            S_ADD: begin
                ctrl.add_step = 1'b1;
                if (stat.add_hit || stat.add_last) begin
                    state_next = S_DONE;
                end
            end
            S_SCHED: begin
                ctrl.sched_step = 1'b1;
                if (stat.sched_last) begin
                    state_next = S_SCHED_END;
                end
            end
            S_SCHED_END: begin
                ctrl.sched_end = 1'b1;
                state_next     = S_DONE;
            end
            S_EV_RD: begin
                ctrl.ev_read = 1'b1;
                state_next   = S_EV_UPD;
            end
            S_EV_UPD: begin
                ctrl.ev_update = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/pts_dpath.sv =====
module pts_dpath #(
    parameter int TASKS      = 8,
    parameter int EVENT_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pts_pkg::pts_ctrl_t           ctrl,
    output pts_pkg::pts_stat_t           stat,
    input  logic [2:0]                   in_cmd,
    input  logic [$clog2(TASKS)-1:0]     in_task,
    input  logic [pts_pkg::PRIO_W-1:0]   in_prio,
    input  logic [EVENT_BITS-1:0]        in_events,
    input  logic                         m_tready,
    output logic                         out_vld,
    output logic [$clog2(TASKS+1)-1:0]   out_idx,
    output logic [EVENT_BITS-1:0]        out_events,
    output logic [1:0]                   out_status
);

    localparam int TW = $clog2(TASKS);
    localparam int IW = $clog2(TASKS + 1);
    localparam int PW = pts_pkg::PRIO_W;
    localparam int EB = EVENT_BITS;

    // command word
    logic [2:0]    cmd_reg;
    logic [TW-1:0] task_reg;
    logic [PW-1:0] prio_reg;
    logic [EB-1:0] evin_reg;

    // task table
    logic [1:0]    slot_state_reg [TASKS];
    logic          ev_vld_reg [TASKS];
    logic [TW-1:0] cur_reg;

    // scan state
    logic [IW-1:0] cnt_reg;
    logic [TW-1:0] k_reg;
    logic          pipe_vld_reg;
    logic          pipe_rdy_reg;
    logic [TW-1:0] pipe_k_reg;
    logic          found_reg;
    logic [TW-1:0] best_reg;
    logic [PW-1:0] best_prio_reg;

    // pending result and output word
    logic [IW-1:0] res_idx_reg;
    logic [EB-1:0] res_ev_reg;
    logic [1:0]    res_st_reg;
    logic          out_vld_reg;
    logic [IW-1:0] out_idx_reg;
    logic [EB-1:0] out_ev_reg;
    logic [1:0]    out_st_reg;

    logic [TW-1:0] add_slot;
    logic          add_hit;
    logic          task_ok;
    logic          sched_issue;
    logic          better;
    logic [PW-1:0] prio_dout;
    logic [EB-1:0] ev_dout;
    logic [EB-1:0] ev_cur;
    logic [EB-1:0] ev_new;
    logic          prio_we;
    logic          ev_we;

    assign add_slot    = cnt_reg[TW-1:0];
    assign add_hit     = (slot_state_reg[add_slot] == pts_pkg::ST_EXITED);
    assign task_ok     = ({1'b0, task_reg} < (TW + 1)'(TASKS));
    assign sched_issue = ctrl.sched_step && (cnt_reg < IW'(TASKS));
    assign better      = pipe_vld_reg && pipe_rdy_reg &&
                         (!found_reg || (best_prio_reg <= prio_dout));
    assign ev_cur      = (task_ok && ev_vld_reg[task_reg]) ? ev_dout : '0;
    assign ev_new      = (cmd_reg == pts_pkg::CMD_SET) ? (ev_cur | evin_reg)
                                                       : (ev_cur & ~evin_reg);
    assign prio_we     = ctrl.add_step && add_hit;
    assign ev_we       = ctrl.ev_update && task_ok &&
                         ((cmd_reg == pts_pkg::CMD_SET) || (cmd_reg == pts_pkg::CMD_CLR));

    assign stat.cmd        = cmd_reg;
    assign stat.add_hit    = add_hit;
    assign stat.add_last   = (cnt_reg == IW'(TASKS - 1));
    assign stat.sched_last = (cnt_reg == IW'(TASKS));
    assign stat.out_free   = !out_vld_reg || m_tready;

    assign out_vld    = out_vld_reg;
    assign out_idx    = out_idx_reg;
    assign out_events = out_ev_reg;
    assign out_status = out_st_reg;

    // priorities, written on add and read by the schedule scan
    pts_ram #(.WIDTH(PW), .DEPTH(TASKS)) u_prio_ram (
        .aclk  (aclk),
        .we    (prio_we),
        .waddr (add_slot),
        .wdata (prio_reg),
        .re    (sched_issue),
        .raddr (k_reg),
        .rdata (prio_dout)
    );

    // event flags, valid bit per slot covers the zero reset
    pts_ram #(.WIDTH(EB), .DEPTH(TASKS)) u_ev_ram (
        .aclk  (aclk),
        .we    (ev_we),
        .waddr (task_reg),
        .wdata (ev_new),
        .re    (ctrl.ev_read && task_ok),
        .raddr (task_reg),
        .rdata (ev_dout)
    );

    // command capture
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg  <= in_cmd;
            task_reg <= in_task;
            prio_reg <= in_prio;
            evin_reg <= in_events;
        end
    end

    // slot table and scan start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TASKS; i++) begin
                slot_state_reg[i] <= pts_pkg::ST_EXITED;
                ev_vld_reg[i]     <= 1'b0;
            end
            cur_reg <= '0;
        end else begin
            if (prio_we) begin
                slot_state_reg[add_slot] <= pts_pkg::ST_READY;
            end
            if (ctrl.sched_end && found_reg) begin
                cur_reg <= best_reg;
            end
            if (ctrl.ev_update && task_ok) begin
                case (cmd_reg)
                    pts_pkg::CMD_DEL: begin
                        slot_state_reg[task_reg] <= pts_pkg::ST_EXITED;
                        ev_vld_reg[task_reg]     <= 1'b0;
                    end
                    pts_pkg::CMD_SET: begin
                        ev_vld_reg[task_reg] <= 1'b1;
                        if (slot_state_reg[task_reg] == pts_pkg::ST_WAITING) begin
                            slot_state_reg[task_reg] <= pts_pkg::ST_READY;
                        end
                    end
                    pts_pkg::CMD_CLR: ev_vld_reg[task_reg] <= 1'b1;
                    pts_pkg::CMD_GCLR: ev_vld_reg[task_reg] <= 1'b0;
                    pts_pkg::CMD_WAIT: begin
                        if (slot_state_reg[task_reg] == pts_pkg::ST_READY) begin
                            slot_state_reg[task_reg] <= pts_pkg::ST_WAITING;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // scan counters and best-so-far
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cnt_reg      <= '0;
            k_reg        <= cur_reg;
            pipe_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            if (ctrl.add_step || ctrl.sched_step) begin
                cnt_reg <= cnt_reg + IW'(1);
            end
            if (ctrl.sched_step) begin
                pipe_vld_reg <= sched_issue;
                pipe_rdy_reg <= (slot_state_reg[k_reg] == pts_pkg::ST_READY);
                pipe_k_reg   <= k_reg;
                k_reg        <= (k_reg == TW'(TASKS - 1)) ? '0 : k_reg + TW'(1);
                if (better) begin
                    found_reg     <= 1'b1;
                    best_reg      <= pipe_k_reg;
                    best_prio_reg <= prio_dout;
                end
            end
        end
    end

    // result of the finished command
    always_ff @(posedge aclk) begin
        if (ctrl.add_step) begin
            res_ev_reg <= '0;
            if (add_hit) begin
                res_idx_reg <= IW'(add_slot);
                res_st_reg  <= pts_pkg::STAT_OK;
            end else begin
                res_idx_reg <= IW'(TASKS);
                res_st_reg  <= pts_pkg::STAT_FULL;
            end
        end else if (ctrl.sched_end) begin
            res_ev_reg <= '0;
            if (found_reg) begin
                res_idx_reg <= IW'(best_reg);
                res_st_reg  <= pts_pkg::STAT_OK;
            end else begin
                res_idx_reg <= IW'(TASKS);
                res_st_reg  <= pts_pkg::STAT_IDLE;
            end
        end else if (ctrl.ev_update) begin
            res_idx_reg <= '0;
            res_st_reg  <= pts_pkg::STAT_OK;
            if ((cmd_reg == pts_pkg::CMD_GET) || (cmd_reg == pts_pkg::CMD_GCLR)) begin
                res_ev_reg <= ev_cur;
            end else begin
                res_ev_reg <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            out_idx_reg <= res_idx_reg;
            out_ev_reg  <= res_ev_reg;
            out_st_reg  <= res_st_reg;
        end
    end

endmodule

// ===== sv/priority_task_scheduler_with_events.sv =====
// channel | dir | tdata fields, lowest bit first
// s_      | in  | command, task_req, priority_req, event_flags
// m_      | out | task_index, events, status
//
// event commands pass through dispatch, event read and event update states; add checks
// one slot of the state table per cycle, schedule does one priority memory read
// per cycle in rotation from the current task
// one command is in work at a time; the next word can be taken in the cycle after a result loads
// a finished result waits in the output register while the next word is taken
// synchronous reset clears the whole task table
module priority_task_scheduler_with_events #(
    parameter int TASKS      = 8,
    parameter int EVENT_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // command, task_req, priority_req, event_flags
    input  logic [((3 + $clog2(TASKS) + 8 + EVENT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // task_index, events, status
    output logic [(($clog2(TASKS + 1) + EVENT_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int TW     = $clog2(TASKS);
    localparam int IW     = $clog2(TASKS + 1);
    localparam int PW     = pts_pkg::PRIO_W;
    localparam int OUT_TD = ((IW + EVENT_BITS + 2 + 7) / 8) * 8;

    pts_pkg::pts_ctrl_t ctrl;
    pts_pkg::pts_stat_t stat;

    logic [IW-1:0]         out_idx;
    logic [EVENT_BITS-1:0] out_events;
    logic [1:0]            out_status;

    pts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    pts_dpath #(.TASKS(TASKS), .EVENT_BITS(EVENT_BITS)) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .stat       (stat),
        .in_cmd     (s_tdata[2:0]),
        .in_task    (s_tdata[3 +: TW]),
        .in_prio    (s_tdata[3 + TW +: PW]),
        .in_events  (s_tdata[3 + TW + PW +: EVENT_BITS]),
        .m_tready   (m_tready),
        .out_vld    (m_tvalid),
        .out_idx    (out_idx),
        .out_events (out_events),
        .out_status (out_status)
    );

    // pack result word, zero padded to bytes
    assign m_tdata = OUT_TD'({out_status, out_events, out_idx});

endmodule

// ===== sv/pts_checker.sv =====
`include "priority_task_scheduler_with_events_assert.svh"

module pts_checker #(
    parameter int TASKS      = 8,
    parameter int EVENT_BITS = 16
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [(($clog2(TASKS + 1) + EVENT_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int IW = $clog2(TASKS + 1);

    logic [IW-1:0]         idx;
    logic [EVENT_BITS-1:0] ev;
    logic [1:0]            st;
    logic                  s_word;
    logic                  none_idx;
    logic                  get_word;

    assign idx      = m_tdata[IW-1:0];
    assign ev       = m_tdata[IW +: EVENT_BITS];
    assign st       = m_tdata[IW + EVENT_BITS +: 2];
    assign s_word   = s_tvalid && s_tready;
    assign none_idx = (idx == IW'(TASKS));
    assign get_word = (idx == '0) && (st == pts_pkg::STAT_OK);

    // full table and idle schedule both name no slot
    `PTS_CHK_NOW(a_full_idx, m_tvalid && (st == pts_pkg::STAT_FULL), none_idx, "full, index set")
    `PTS_CHK_NOW(a_idle_idx, m_tvalid && (st == pts_pkg::STAT_IDLE), none_idx, "idle, index set")
    // event bits only come back from a get or get-and-clear, which return index zero
    `PTS_CHK_NOW(a_ev_get, m_tvalid && (ev != '0), get_word, "events on non-get word")
    // one command in work at a time
    `PTS_CHK_NEXT(a_busy, s_word, !s_tready, "word taken while busy")
    // stalled result holds
    `PTS_CHK_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind priority_task_scheduler_with_events pts_checker #(
    .TASKS      (TASKS),
    .EVENT_BITS (EVENT_BITS)
) u_pts_checker (.*);

// ===== tb/sv/tb_priority_task_scheduler_with_events.sv =====
`timescale 1ns / 100ps

module tb_priority_task_scheduler_with_events;

    localparam int TASKS        = 8;
    localparam int EVENT_BITS   = 16;
    localparam int S_W          = 32;
    localparam int M_W          = 24;
    localparam int RANDOM_WORDS = 1525;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 3 * (TASKS + 4);

    // one command word as driven on s_tdata
    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  slot;
        logic [7:0]  prio;
        logic [15:0] flags;
    } sched_cmd_t;

    // one result word as seen on m_tdata
    typedef struct packed {
        logic [3:0]  task_index;
        logic [15:0] events;
        logic [1:0]  status;
    } sched_result_t;

    // directed row: command plus an optional hand-typed result
    typedef struct {
        sched_cmd_t    word;
        bit            fixed;
        sched_result_t result;
    } directed_row_t;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    // command, task_req, priority_req, event_flags
    logic [S_W-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    // task_index, events, status
    logic [M_W-1:0] m_tdata;

    // shadow copy of the task table
    logic [1:0]     task_state  [TASKS];
    logic [7:0]     task_prio   [TASKS];
    logic [15:0]    task_events [TASKS];
    int             scan_start;

    sched_result_t  pending_results[$];
    directed_row_t  directed_rows[$];
    int             error_count;
    int             idle_cycles;
    bit             steady;

    priority_task_scheduler_with_events #(
        .TASKS      (TASKS),
        .EVENT_BITS (EVENT_BITS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // task table behavior: update the shadow table, return the result word
    function automatic sched_result_t apply_command(input sched_cmd_t w);
        sched_result_t r;
        bit            found;
        int            best;
        int            k;
        r = '0;
        case (w.cmd)
            pts_pkg::CMD_ADD: begin
                r.task_index = 4'(TASKS);
                r.status     = pts_pkg::STAT_FULL;
                for (int i = 0; i < TASKS; i++) begin
                    if (r.status == pts_pkg::STAT_FULL &&
                        task_state[i] == pts_pkg::ST_EXITED) begin
                        task_state[i] = pts_pkg::ST_READY;
                        task_prio[i]  = w.prio;
                        r.task_index  = 4'(i);
                        r.status      = pts_pkg::STAT_OK;
                    end
                end
            end
            pts_pkg::CMD_DEL: begin
                task_state[w.slot]  = pts_pkg::ST_EXITED;
                task_prio[w.slot]   = '0;
                task_events[w.slot] = '0;
            end
            pts_pkg::CMD_SCHED: begin
                found = 1'b0;
                best  = 0;
                // rotate from the scan start, ties go to the later slot
                for (int i = 0; i < TASKS; i++) begin
                    k = (i + scan_start) % TASKS;
                    if (task_state[k] == pts_pkg::ST_READY &&
                        (!found || task_prio[best] <= task_prio[k])) begin
                        best  = k;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    scan_start   = best;
                    r.task_index = 4'(best);
                end else begin
                    r.task_index = 4'(TASKS);
                    r.status     = pts_pkg::STAT_IDLE;
                end
            end
            pts_pkg::CMD_SET: begin
                task_events[w.slot] = task_events[w.slot] | w.flags;
                if (task_state[w.slot] == pts_pkg::ST_WAITING)
                    task_state[w.slot] = pts_pkg::ST_READY;
            end
            pts_pkg::CMD_CLR: begin
                task_events[w.slot] = task_events[w.slot] & ~w.flags;
            end
            pts_pkg::CMD_GET: begin
                r.events = task_events[w.slot];
            end
            pts_pkg::CMD_GCLR: begin
                r.events            = task_events[w.slot];
                task_events[w.slot] = '0;
            end
            default: begin
                if (task_state[w.slot] == pts_pkg::ST_READY)
                    task_state[w.slot] = pts_pkg::ST_WAITING;
            end
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [2:0] slot,
                           input logic [7:0] prio, input logic [15:0] flags,
                           input bit fixed, input logic [3:0] idx,
                           input logic [15:0] ev, input logic [1:0] st);
        directed_row_t row;
        row.word   = '{cmd: cmd, slot: slot, prio: prio, flags: flags};
        row.fixed  = fixed;
        row.result = '{task_index: idx, events: ev, status: st};
        directed_rows.push_back(row);
    endtask

    // drive one word with random gaps, queue its result once it is taken
    task automatic send_word(input sched_cmd_t w, input bit fixed,
                             input sched_result_t fixed_result);
        sched_result_t predicted;
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, w.flags, w.prio, w.slot, w.cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_command(w);
        pending_results.push_back(fixed ? fixed_result : predicted);
    endtask

    function automatic sched_cmd_t random_word();
        sched_cmd_t w;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 14)      w.cmd = pts_pkg::CMD_ADD;
        else if (pick < 24) w.cmd = pts_pkg::CMD_DEL;
        else if (pick < 46) w.cmd = pts_pkg::CMD_SCHED;
        else if (pick < 60) w.cmd = pts_pkg::CMD_SET;
        else if (pick < 68) w.cmd = pts_pkg::CMD_CLR;
        else if (pick < 78) w.cmd = pts_pkg::CMD_GET;
        else if (pick < 86) w.cmd = pts_pkg::CMD_GCLR;
        else                w.cmd = pts_pkg::CMD_WAIT;
        w.slot = 3'($urandom_range(0, TASKS - 1));
        // small priorities give ties so the rotation matters
        w.prio = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3))
                                             : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick == 0)      w.flags = 16'hFFFF;
        else if (pick == 1) w.flags = 16'h0000;
        else                w.flags = 16'($urandom);
        return w;
    endfunction

    // result checker and stall watch
    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got.task_index = m_tdata[3:0];
            got.events     = m_tdata[19:4];
            got.status     = m_tdata[21:20];
            if (pending_results.size() == 0) begin
                error_count = error_count + 1;
                if (error_count <= 10)
                    $display("unexpected result word: index %0d events %h status %0d",
                             got.task_index, got.events, got.status);
            end else begin
                want = pending_results.pop_front();
                if (got.task_index !== want.task_index || got.events !== want.events ||
                    got.status !== want.status) begin
                    error_count = error_count + 1;
                    if (error_count <= 10)
                        $display("mismatch: expected index %0d events %h status %0d,",
                                 want.task_index, want.events, want.status,
                                 " got index %0d events %h status %0d",
                                 got.task_index, got.events, got.status);
                end
            end
        end
    end

    // watchdog: too long with no word moving on either side
    initial begin
        @(posedge aresetn);
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= steady || ($urandom_range(0, 99) >= 23);
        end
    end

    // reset, directed table, random commands, drain
    initial begin
        sched_cmd_t w;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        aresetn     = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        steady      = 1'b0;
        scan_start  = 0;
        for (int i = 0; i < TASKS; i++) begin
            task_state[i]  = pts_pkg::ST_EXITED;
            task_prio[i]   = '0;
            task_events[i] = '0;
        end

        // empty table, extremes, full table, event paths, wait and wake
        add_row(pts_pkg::CMD_SCHED, 3'd0, 8'd0,   16'h0000, 1, 4'd8, 16'h0000,
                pts_pkg::STAT_IDLE);
        add_row(pts_pkg::CMD_GET,   3'd7, 8'd0,   16'h0000, 1, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_ADD,   3'd0, 8'd255, 16'h0000, 1, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_ADD,   3'd7, 8'd0,   16'hFFFF, 1, 4'd1, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_ADD,   3'd2, 8'd7,   16'h0000, 1, 4'd2, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_ADD,   3'd5, 8'd7,   16'h0000, 1, 4'd3, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_ADD,   3'd0, 8'd128, 16'h0000, 1, 4'd4, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_ADD,   3'd0, 8'd1,   16'h0000, 1, 4'd5, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_ADD,   3'd0, 8'd7,   16'h0000, 1, 4'd6, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_ADD,   3'd0, 8'd255, 16'h0000, 1, 4'd7, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_ADD,   3'd0, 8'd9,   16'h0000, 1, 4'd8, 16'h0000,
                pts_pkg::STAT_FULL);
        add_row(pts_pkg::CMD_SET,   3'd3, 8'd0,   16'hFFFF, 1, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_GET,   3'd3, 8'd255, 16'h0000, 1, 4'd0, 16'hFFFF,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_CLR,   3'd3, 8'd0,   16'h00FF, 0, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_GCLR,  3'd3, 8'd0,   16'h0000, 0, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_GET,   3'd3, 8'd0,   16'h0000, 0, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_WAIT,  3'd0, 8'd0,   16'h0000, 0, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_SCHED, 3'd0, 8'd0,   16'h0000, 0, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_WAIT,  3'd0, 8'd0,   16'h0000, 0, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_SET,   3'd0, 8'd0,   16'h8001, 0, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_SCHED, 3'd0, 8'd0,   16'h0000, 0, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_DEL,   3'd0, 8'd0,   16'h0000, 0, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_SET,   3'd0, 8'd0,   16'h5AA5, 0, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_ADD,   3'd0, 8'd3,   16'h0000, 0, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);
        add_row(pts_pkg::CMD_GCLR,  3'd0, 8'd0,   16'h0000, 0, 4'd0, 16'h0000,
                pts_pkg::STAT_OK);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].result);

        // random commands, with a stretch of no gaps or stalls in the middle
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady = (n >= 700 && n < 1000);
            w = random_word();
            send_word(w, 1'b0, '0);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        steady = 1'b0;

        // wait for every queued result, then watch for strays
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/pts_pkg.sv
sv/pts_ram.sv
sv/pts_ctrl.sv
sv/pts_dpath.sv
sv/priority_task_scheduler_with_events.sv
sv/pts_checker.sv
tb/sv/tb_priority_task_scheduler_with_events.sv
